// File: design/l2mswz_pkg.sv
// ----------------------------------------------------------------------------
// l2mswz_pkg
// Types, register indexes and helper functions for the Morton tile swizzle.
// ----------------------------------------------------------------------------
package l2mswz_pkg;

  localparam int unsigned MaxTexSize = 1024;
  localparam int unsigned MaxSrcSize = 4096;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 13;

  localparam logic [CfgIdxW-1:0] REG_SRC_X0         = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SRC_Y0         = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_COPY_WIDTH     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_COPY_HEIGHT    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_FULL_SRC_WIDTH = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_TEX_WIDTH      = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_TEX_HEIGHT     = 3'd6;

  typedef struct packed {
    logic [9:0]  tex_x;
    logic [9:0]  tex_y;
    logic [31:0] src_pixel;
  } texel_in_t;

  typedef struct packed {
    logic [21:0] dst_offset;
    logic [31:0] dst_pixel;
    logic [26:0] src_offset;
    logic        in_copy;
    logic        last_texel;
  } texel_out_t;

  function automatic logic [5:0] morton3(input logic [2:0] x, input logic [2:0] y);
    return {y[2], x[2], y[1], x[1], y[0], x[0]};
  endfunction

  function automatic logic [31:0] byte_reverse(input logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

endpackage

// File: design/linear_to_morton_tile_swizzle.sv
// ----------------------------------------------------------------------------
// linear_to_morton_tile_swizzle
// Converts texel positions and source words into source and 8x8 Morton tiled
// destination offsets and the byte-reversed or zeroed destination word.
//
// A word is issued on din by raising start; busy is always low, so a new word
// may be issued in every cycle. Each issued word yields one result on dout,
// marked by a one-cycle done strobe, after the stage 1, stage 2 and output
// registers. The receiver cannot stall, so results are never held. Throughput
// is one word per cycle; the three stages are input register with address
// sums, the 13 by 13 bit and 7 by 8 bit multipliers, and the final adds into
// the output register. Configuration is written through wr_en, wr_index and
// wr_data; the user must write it only while no word is in flight, a rule the
// block leaves unenforced. Synchronous reset empties the pipeline and restores
// the register defaults: origin zero, copy region, pitch and texture 1024.
// ----------------------------------------------------------------------------
module linear_to_morton_tile_swizzle
  import l2mswz_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  texel_in_t           din,
  output logic                done,
  output texel_out_t          dout,
  input  logic                wr_en,
  input  logic [CfgIdxW-1:0]  wr_index,
  input  logic [CfgDataW-1:0] wr_data
);

  logic [11:0] src_x0;
  logic [11:0] src_y0;
  logic [10:0] copy_width;
  logic [10:0] copy_height;
  logic [12:0] full_src_width;
  logic [10:0] tex_width;
  logic [10:0] tex_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_x0         <= '0;
      src_y0         <= '0;
      copy_width     <= 11'd1024;
      copy_height    <= 11'd1024;
      full_src_width <= 13'd1024;
      tex_width      <= 11'd1024;
      tex_height     <= 11'd1024;
    end else if (wr_en) begin
      case (wr_index)
        REG_SRC_X0:         src_x0         <= wr_data[11:0];
        REG_SRC_Y0:         src_y0         <= wr_data[11:0];
        REG_COPY_WIDTH:     copy_width     <= wr_data[10:0];
        REG_COPY_HEIGHT:    copy_height    <= wr_data[10:0];
        REG_FULL_SRC_WIDTH: full_src_width <= wr_data[12:0];
        REG_TEX_WIDTH:      tex_width      <= wr_data[10:0];
        REG_TEX_HEIGHT:     tex_height     <= wr_data[10:0];
        default: ;
      endcase
    end
  end

  logic [10:0] tw_sat;
  logic [10:0] th_sat;
  logic [12:0] pitch_sat;
  logic [10:0] last_col;
  logic [10:0] last_row;

  always_comb begin
    tw_sat    = (tex_width > 11'(MaxTexSize)) ? 11'(MaxTexSize) : tex_width;
    th_sat    = (tex_height > 11'(MaxTexSize)) ? 11'(MaxTexSize) : tex_height;
    pitch_sat = (full_src_width > 13'(MaxSrcSize)) ? 13'(MaxSrcSize) : full_src_width;
    last_col  = (tw_sat - 11'd1) | 11'd7;
    last_row  = (th_sat - 11'd1) | 11'd7;
  end

  // Stage 1: registered word, address sums and flags.
  logic        s1_valid;
  logic [12:0] s1_ysum;
  logic [12:0] s1_xsum;
  logic [6:0]  s1_ytile;
  logic [6:0]  s1_xtile;
  logic [7:0]  s1_tiles_per_row;
  logic [5:0]  s1_morton;
  logic [31:0] s1_word;
  logic        s1_inside;
  logic        s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start;
    end
  end

  always_ff @(posedge clk) begin
    s1_ysum          <= 13'(src_y0) + 13'(din.tex_y);
    s1_xsum          <= 13'(src_x0) + 13'(din.tex_x);
    s1_ytile         <= din.tex_y[9:3];
    s1_xtile         <= din.tex_x[9:3];
    s1_tiles_per_row <= tw_sat[10:3];
    s1_morton        <= morton3(din.tex_x[2:0], din.tex_y[2:0]);
    s1_inside        <= (11'(din.tex_x) < copy_width) && (11'(din.tex_y) < copy_height);
    s1_word          <= (din.src_pixel[31:24] != 8'd0) ? byte_reverse(din.src_pixel) : '0;
    s1_last          <= (tw_sat != '0) && (th_sat != '0) &&
                        (11'(din.tex_x) == last_col) && (11'(din.tex_y) == last_row);
  end

  // Stage 2: products.
  logic        s2_valid;
  logic [25:0] s2_row_off;
  logic [14:0] s2_tile_row;
  logic [12:0] s2_xsum;
  logic [6:0]  s2_xtile;
  logic [5:0]  s2_morton;
  logic [31:0] s2_word;
  logic        s2_inside;
  logic        s2_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_row_off  <= 26'(s1_ysum) * 26'(pitch_sat);
    s2_tile_row <= 15'(s1_ytile) * 15'(s1_tiles_per_row);
    s2_xsum     <= s1_xsum;
    s2_xtile    <= s1_xtile;
    s2_morton   <= s1_morton;
    s2_word     <= s1_inside ? s1_word : '0;
    s2_inside   <= s1_inside;
    s2_last     <= s1_last;
  end

  // Stage 3: final sums into the output register.
  logic [24:0] src_sum;
  logic [13:0] tile_sum;

  always_comb begin
    src_sum  = 25'(s2_row_off) + 25'(s2_xsum);
    tile_sum = 14'(s2_tile_row) + 14'(s2_xtile);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    dout.dst_offset <= {tile_sum, s2_morton, 2'b00};
    dout.dst_pixel  <= s2_word;
    dout.src_offset <= s2_inside ? {src_sum, 2'b00} : '0;
    dout.in_copy    <= s2_inside;
    dout.last_texel <= s2_last;
  end

  assign busy = 1'b0;

  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##3 done)
    else $error("result strobe did not follow an issued word");

  a_s2_follows_s1: assert property (@(posedge clk) disable iff (rst)
    s2_valid == $past(s1_valid))
    else $error("stage valid bits out of step");

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    done && !dout.in_copy |-> (dout.dst_pixel == '0) && (dout.src_offset == '0))
    else $error("texel outside the copy region produced data");

  a_word_aligned: assert property (@(posedge clk) disable iff (rst)
    done |-> (dout.dst_offset[1:0] == 2'b00) && (dout.src_offset[1:0] == 2'b00))
    else $error("offset not word aligned");

endmodule
